>>> src/trhc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt reference heading corrector package
// Widths, constants, register indexes, pipeline payload types and the small
// arithmetic helpers that the stages of the corrector share.
// ----------------------------------------------------------------------------
package trhc_pkg;

  localparam int AngleW    = 16;   // angle fields, 1/128 degree
  localparam int FracW     = 16;   // fraction bits of the filter accumulators
  localparam int FiltW     = 32;   // filter accumulator
  localparam int TimeW     = 32;   // microsecond accumulators
  localparam int IntervalW = 20;
  localparam int GainW     = 17;
  localparam int MsW       = 16;
  localparam int LimW      = 15;
  localparam int MagW      = 17;   // magnitude of an angle, up to 32768
  localparam int DecW      = 17;   // decay step per sample
  localparam int ProdW     = 36;   // decay rate times interval
  localparam int CfgIdxW   = 4;
  localparam int CfgDataW  = 17;

  localparam logic [GainW-1:0] GainOne = 17'h10000;
  localparam logic [TimeW-1:0] UsPerMs = 32'd1000;

  localparam int MinEffectiveOutput = 64;
  localparam int LearnImproveEps    = 6;

  // floor(x / 1000000) = floor((x >> 6) / 15625); the second step is a
  // multiplication by a rounded-up reciprocal, exact for x >> 6 below 2^30.
  localparam int DecayShift      = 6;
  localparam int RecipW          = 31;
  localparam int DecayRecipShift = 44;
  localparam logic [RecipW-1:0] DecayRecip = 31'd1125899907;

  typedef enum logic [1:0] {
    MODE_UNINIT = 2'd0,
    MODE_LEARN  = 2'd1,
    MODE_TRACK  = 2'd2
  } mode_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WARMUP_TIME    = 4'd0,
    REG_HOLD_TIME      = 4'd1,
    REG_PITCH_GAIN     = 4'd2,
    REG_ROLL_GAIN      = 4'd3,
    REG_DECAY_RATE     = 4'd4,
    REG_DROP_THRESHOLD = 4'd5,
    REG_DEAD_BAND      = 4'd6,
    REG_OUTPUT_LIMIT   = 4'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [MsW-1:0]   warmup_time_ms;
    logic [MsW-1:0]   hold_time_ms;
    logic [GainW-1:0] pitch_filter_gain;
    logic [GainW-1:0] roll_filter_gain;
    logic [MsW-1:0]   best_decay_rate;
    logic [LimW-1:0]  drop_threshold;
    logic [LimW-1:0]  roll_dead_band;
    logic [LimW-1:0]  output_limit;
  } cfg_t;

  typedef struct packed {
    logic                     enable;
    logic [IntervalW-1:0]     interval_us;
    logic signed [AngleW-1:0] roll_angle;
    logic signed [AngleW-1:0] pitch_angle;
  } sample_t;

  // Filter stage to decay stage.
  typedef struct packed {
    logic                    enable;
    logic                    clear;
    logic                    window_ready;
    logic [IntervalW-1:0]    interval_us;
    logic [ProdW-1:0]        decay_product;
    logic signed [FiltW-1:0] pitch_filtered;
    logic signed [FiltW-1:0] roll_filtered;
  } filt_t;

  // Decay stage to mode stage.
  typedef struct packed {
    logic                     enable;
    logic                     clear;
    logic                     window_ready;
    logic [IntervalW-1:0]     interval_us;
    logic [DecW-1:0]          decay;
    logic signed [AngleW-1:0] pitch_angle;
    logic signed [AngleW-1:0] roll_angle;
  } tilt_t;

  function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
                                               input logic [IntervalW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {{(TimeW-IntervalW+1){1'b0}}, b};
    return s[TimeW] ? {TimeW{1'b1}} : s[TimeW-1:0];
  endfunction

  function automatic logic [TimeW-1:0] ms_to_us(input logic [MsW-1:0] ms);
    return TimeW'(ms) * UsPerMs;
  endfunction

  // Round half up of an accumulator back to angle units.
  function automatic logic signed [AngleW-1:0] angle_of(input logic signed [FiltW-1:0] f);
    logic signed [FiltW:0] t;
    t = {f[FiltW-1], f} + (FiltW+1)'(33'sd32768);
    return t[FracW+AngleW-1:FracW];
  endfunction

endpackage

>>> src/trhc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt reference heading corrector channels
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
interface trhc_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [trhc_pkg::AngleW-1:0]  pitch_angle;
  logic signed [trhc_pkg::AngleW-1:0]  roll_angle;
  logic [trhc_pkg::IntervalW-1:0]      interval_us;
  logic                                enable;

  modport source(output valid, pitch_angle, roll_angle, interval_us, enable, input ready);
  modport sink(input valid, pitch_angle, roll_angle, interval_us, enable, output ready);
endinterface

interface trhc_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [trhc_pkg::AngleW-1:0]  correction;
  logic [1:0]                          mode;

  modport source(output valid, correction, mode, input ready);
  modport sink(input valid, correction, mode, output ready);
endinterface

interface trhc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [trhc_pkg::CfgIdxW-1:0]     index;
  logic [trhc_pkg::CfgDataW-1:0]    data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> src/trhc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the eight tuning registers; writes beyond the list are dropped.
// ----------------------------------------------------------------------------
module trhc_cfg_regs (
  input  logic             clk,
  input  logic             rst,
  trhc_cfg_if.sink         cfg,
  output trhc_pkg::cfg_t   regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.warmup_time_ms    <= 16'd500;
      regs.hold_time_ms      <= 16'd200;
      regs.pitch_filter_gain <= 17'd16384;
      regs.roll_filter_gain  <= 17'd16384;
      regs.best_decay_rate   <= 16'd0;
      regs.drop_threshold    <= 15'd128;
      regs.roll_dead_band    <= 15'd64;
      regs.output_limit      <= 15'd1280;
    end else if (cfg.valid) begin
      case (trhc_pkg::cfg_idx_t'(cfg.index))
        trhc_pkg::REG_WARMUP_TIME:    regs.warmup_time_ms    <= cfg.data[trhc_pkg::MsW-1:0];
        trhc_pkg::REG_HOLD_TIME:      regs.hold_time_ms      <= cfg.data[trhc_pkg::MsW-1:0];
        trhc_pkg::REG_PITCH_GAIN:     regs.pitch_filter_gain <= cfg.data;
        trhc_pkg::REG_ROLL_GAIN:      regs.roll_filter_gain  <= cfg.data;
        trhc_pkg::REG_DECAY_RATE:     regs.best_decay_rate   <= cfg.data[trhc_pkg::MsW-1:0];
        trhc_pkg::REG_DROP_THRESHOLD: regs.drop_threshold    <= cfg.data[trhc_pkg::LimW-1:0];
        trhc_pkg::REG_DEAD_BAND:      regs.roll_dead_band    <= cfg.data[trhc_pkg::LimW-1:0];
        trhc_pkg::REG_OUTPUT_LIMIT:   regs.output_limit      <= cfg.data[trhc_pkg::LimW-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

>>> src/trhc_filter_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Filter stage
// Input register, enable tracking, pitch and roll low-pass filters, the
// stable window counters and the raw decay product.
// ----------------------------------------------------------------------------
module trhc_filter_stage (
  input  logic             clk,
  input  logic             rst,
  trhc_sample_if.sink      sample,
  input  trhc_pkg::cfg_t   regs,
  output logic             filt_valid,
  output trhc_pkg::filt_t  filt,
  input  logic             filt_ready
);

  function automatic logic signed [trhc_pkg::FiltW-1:0] iir_update(
      input logic signed [trhc_pkg::FiltW-1:0]  f,
      input logic signed [trhc_pkg::AngleW-1:0] s,
      input logic [trhc_pkg::GainW-1:0]         gain);
    logic signed [trhc_pkg::FiltW:0]                 target;
    logic signed [trhc_pkg::FiltW:0]                 diff;
    logic signed [trhc_pkg::FiltW+trhc_pkg::GainW:0] prod;
    logic signed [trhc_pkg::FiltW+trhc_pkg::GainW:0] step;
    target = {s[trhc_pkg::AngleW-1], s, {trhc_pkg::FracW{1'b0}}};
    if (gain >= trhc_pkg::GainOne) begin
      return target[trhc_pkg::FiltW-1:0];
    end
    diff = target - {f[trhc_pkg::FiltW-1], f};
    prod = $signed({1'b0, gain[trhc_pkg::GainW-2:0]}) * diff;
    step = prod >>> trhc_pkg::FracW;
    return f + step[trhc_pkg::FiltW-1:0];
  endfunction

  logic                                 held_valid;
  trhc_pkg::sample_t                    held;
  logic                                 advance;

  logic                                 enabled_flag;
  logic                                 filters_seeded;
  logic signed [trhc_pkg::FiltW-1:0]    pitch_filtered;
  logic signed [trhc_pkg::FiltW-1:0]    roll_filtered;
  logic [trhc_pkg::TimeW-1:0]           stable_time_us;
  logic [1:0]                           stable_samples;

  logic                                 clear;
  logic                                 seeded_next;
  logic signed [trhc_pkg::FiltW-1:0]    pitch_filtered_next;
  logic signed [trhc_pkg::FiltW-1:0]    roll_filtered_next;
  logic [trhc_pkg::TimeW-1:0]           stable_time_next;
  logic [1:0]                           stable_samples_next;
  logic                                 window_ready;

  assign advance      = held_valid && (!filt_valid || filt_ready);
  assign sample.ready = !held_valid || advance;

  always_comb begin
    clear               = held.enable != enabled_flag;
    seeded_next         = filters_seeded && !clear;
    pitch_filtered_next = clear ? '0 : pitch_filtered;
    roll_filtered_next  = clear ? '0 : roll_filtered;
    stable_time_next    = clear ? '0 : stable_time_us;
    stable_samples_next = clear ? 2'd0 : stable_samples;
    if (held.enable) begin
      // After an enable change the filters are unseeded, so the seed path
      // never sees the stale accumulators.
      pitch_filtered_next = iir_update(pitch_filtered, held.pitch_angle,
                                       seeded_next ? regs.pitch_filter_gain
                                                   : trhc_pkg::GainOne);
      roll_filtered_next  = iir_update(roll_filtered, held.roll_angle,
                                       seeded_next ? regs.roll_filter_gain
                                                   : trhc_pkg::GainOne);
      seeded_next         = 1'b1;
      stable_time_next    = trhc_pkg::sat_add(stable_time_next, held.interval_us);
      stable_samples_next = (stable_samples_next == 2'd2) ? 2'd2 : stable_samples_next + 2'd1;
    end
    window_ready = (stable_samples_next == 2'd2) &&
                   (stable_time_next >= trhc_pkg::ms_to_us(regs.warmup_time_ms));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid     <= 1'b0;
      filt_valid     <= 1'b0;
      enabled_flag   <= 1'b0;
      filters_seeded <= 1'b0;
      pitch_filtered <= '0;
      roll_filtered  <= '0;
      stable_time_us <= '0;
      stable_samples <= 2'd0;
    end else begin
      if (sample.valid && sample.ready) begin
        held_valid <= 1'b1;
      end else if (advance) begin
        held_valid <= 1'b0;
      end
      if (advance) begin
        filt_valid     <= 1'b1;
        enabled_flag   <= held.enable;
        filters_seeded <= seeded_next;
        pitch_filtered <= pitch_filtered_next;
        roll_filtered  <= roll_filtered_next;
        stable_time_us <= stable_time_next;
        stable_samples <= stable_samples_next;
      end else if (filt_ready) begin
        filt_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      held.enable      <= sample.enable;
      held.interval_us <= sample.interval_us;
      held.roll_angle  <= sample.roll_angle;
      held.pitch_angle <= sample.pitch_angle;
    end
    if (advance) begin
      filt.enable         <= held.enable;
      filt.clear          <= clear;
      filt.window_ready   <= window_ready;
      filt.interval_us    <= held.interval_us;
      filt.decay_product  <= trhc_pkg::ProdW'(regs.best_decay_rate) *
                             trhc_pkg::ProdW'(held.interval_us);
      filt.pitch_filtered <= pitch_filtered_next;
      filt.roll_filtered  <= roll_filtered_next;
    end
  end

endmodule

>>> src/trhc_decay_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decay stage
// Rounds the filter accumulators back to angles and turns the decay product
// into whole angle units per sample.
// ----------------------------------------------------------------------------
module trhc_decay_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             filt_valid,
  input  trhc_pkg::filt_t  filt,
  output logic             filt_ready,
  output logic             tilt_valid,
  output trhc_pkg::tilt_t  tilt,
  input  logic             tilt_ready
);

  localparam int ScaledW = trhc_pkg::ProdW - trhc_pkg::DecayShift;
  localparam int QuotW   = ScaledW + trhc_pkg::RecipW;

  logic                 advance;
  logic [ScaledW-1:0]   scaled;
  logic [QuotW-1:0]     quot_full;

  assign filt_ready = !tilt_valid || tilt_ready;
  assign advance    = filt_valid && filt_ready;

  assign scaled    = filt.decay_product[trhc_pkg::ProdW-1:trhc_pkg::DecayShift];
  assign quot_full = QuotW'(scaled) * QuotW'(trhc_pkg::DecayRecip);

  always_ff @(posedge clk) begin
    if (rst) begin
      tilt_valid <= 1'b0;
    end else if (advance) begin
      tilt_valid <= 1'b1;
    end else if (tilt_ready) begin
      tilt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tilt.enable       <= filt.enable;
      tilt.clear        <= filt.clear;
      tilt.window_ready <= filt.window_ready;
      tilt.interval_us  <= filt.interval_us;
      tilt.decay        <= quot_full[trhc_pkg::DecayRecipShift +: trhc_pkg::DecW];
      tilt.pitch_angle  <= trhc_pkg::angle_of(filt.pitch_filtered);
      tilt.roll_angle   <= trhc_pkg::angle_of(filt.roll_filtered);
    end
  end

endmodule

>>> src/trhc_mode_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mode stage
// Mode machine, best pitch learning, drop tracking and the result register.
// ----------------------------------------------------------------------------
module trhc_mode_stage (
  input  logic             clk,
  input  logic             rst,
  input  trhc_pkg::cfg_t   regs,
  input  logic             tilt_valid,
  input  trhc_pkg::tilt_t  tilt,
  output logic             tilt_ready,
  trhc_result_if.source    result
);

  logic                                 advance;

  trhc_pkg::mode_t                      mode_reg;
  logic                                 learned_flag;
  logic [trhc_pkg::MagW-1:0]            best_abs_pitch;
  logic signed [trhc_pkg::AngleW-1:0]   roll_best;
  logic [trhc_pkg::TimeW-1:0]           learn_time_us;
  logic [trhc_pkg::TimeW-1:0]           hold_time_us;

  trhc_pkg::mode_t                      mode_cur;
  logic                                 learned_cur;
  logic [trhc_pkg::MagW-1:0]            best_cur;
  logic signed [trhc_pkg::AngleW-1:0]   roll_best_cur;
  logic [trhc_pkg::TimeW-1:0]           learn_cur;
  logic [trhc_pkg::TimeW-1:0]           hold_cur;

  trhc_pkg::mode_t                      mode_next;
  logic                                 learned_next;
  logic [trhc_pkg::MagW-1:0]            best_next;
  logic signed [trhc_pkg::AngleW-1:0]   roll_best_next;
  logic [trhc_pkg::TimeW-1:0]           learn_next;
  logic [trhc_pkg::TimeW-1:0]           hold_next;
  logic signed [trhc_pkg::AngleW-1:0]   correction_next;

  logic signed [trhc_pkg::MagW-1:0]     pitch_ext;
  logic [trhc_pkg::MagW-1:0]            pitch_mag;
  logic [trhc_pkg::MagW-1:0]            best_decayed;
  logic                                 improve;
  logic [trhc_pkg::MagW-1:0]            best_upd;
  logic signed [trhc_pkg::AngleW-1:0]   roll_best_upd;
  logic signed [trhc_pkg::MagW:0]       drop;
  logic                                 drop_hit;
  logic [trhc_pkg::TimeW-1:0]           hold_upd;
  logic signed [trhc_pkg::MagW-1:0]     roll_dev;
  logic [trhc_pkg::MagW-1:0]            roll_dev_mag;
  logic [trhc_pkg::MagW-1:0]            out_mag;
  logic signed [trhc_pkg::AngleW-1:0]   correction_upd;

  assign tilt_ready   = !result.valid || result.ready;
  assign advance      = tilt_valid && tilt_ready;

  always_comb begin
    // State as seen after an enable change has cleared it.
    mode_cur      = tilt.clear ? trhc_pkg::MODE_UNINIT : mode_reg;
    learned_cur   = learned_flag && !tilt.clear;
    best_cur      = tilt.clear ? '0 : best_abs_pitch;
    roll_best_cur = tilt.clear ? '0 : roll_best;
    learn_cur     = tilt.clear ? '0 : learn_time_us;
    hold_cur      = tilt.clear ? '0 : hold_time_us;

    // Best pitch update with decay.
    pitch_ext = {tilt.pitch_angle[trhc_pkg::AngleW-1], tilt.pitch_angle};
    pitch_mag = pitch_ext[trhc_pkg::MagW-1] ? trhc_pkg::MagW'(-pitch_ext) : pitch_ext;
    if (learned_cur) begin
      best_decayed = (tilt.decay >= best_cur) ? '0 : best_cur - tilt.decay;
    end else begin
      best_decayed = best_cur;
    end
    improve = !learned_cur ||
              ({1'b0, pitch_mag} > {1'b0, best_decayed} +
                                   (trhc_pkg::MagW+1)'(trhc_pkg::LearnImproveEps));
    best_upd      = improve ? pitch_mag : best_decayed;
    roll_best_upd = improve ? tilt.roll_angle : roll_best_cur;

    // Drop tracking against the updated best pitch.
    drop     = $signed({1'b0, best_upd}) - $signed({1'b0, pitch_mag});
    drop_hit = drop > $signed({3'b000, regs.drop_threshold});
    hold_upd = trhc_pkg::sat_add(hold_cur, tilt.interval_us);
    roll_dev = {tilt.roll_angle[trhc_pkg::AngleW-1], tilt.roll_angle} -
               {roll_best_upd[trhc_pkg::AngleW-1], roll_best_upd};
    roll_dev_mag = roll_dev[trhc_pkg::MagW-1] ? trhc_pkg::MagW'(-roll_dev) : roll_dev;
    if (drop > $signed({3'b000, regs.output_limit})) begin
      out_mag = {2'b00, regs.output_limit};
    end else begin
      out_mag = drop[trhc_pkg::MagW-1:0];
    end
    if (out_mag != '0 && out_mag < trhc_pkg::MagW'(trhc_pkg::MinEffectiveOutput)) begin
      out_mag = trhc_pkg::MagW'(trhc_pkg::MinEffectiveOutput);
    end
    correction_upd = roll_dev[trhc_pkg::MagW-1] ? -out_mag[trhc_pkg::AngleW-1:0]
                                                 : out_mag[trhc_pkg::AngleW-1:0];

    mode_next       = mode_cur;
    learned_next    = learned_cur;
    best_next       = best_cur;
    roll_best_next  = roll_best_cur;
    learn_next      = learn_cur;
    hold_next       = hold_cur;
    correction_next = '0;
    if (tilt.enable) begin
      case (mode_cur)
        trhc_pkg::MODE_UNINIT: begin
          if (tilt.window_ready) begin
            mode_next  = trhc_pkg::MODE_LEARN;
            learn_next = '0;
          end
        end
        trhc_pkg::MODE_LEARN: begin
          if (tilt.window_ready) begin
            best_next      = best_upd;
            roll_best_next = roll_best_upd;
            learned_next   = 1'b1;
            learn_next     = trhc_pkg::sat_add(learn_cur, tilt.interval_us);
            if (learn_next >= trhc_pkg::ms_to_us(regs.warmup_time_ms)) begin
              mode_next = trhc_pkg::MODE_TRACK;
              hold_next = '0;
            end
          end
        end
        trhc_pkg::MODE_TRACK: begin
          if (!tilt.window_ready) begin
            hold_next = '0;
          end else begin
            best_next      = best_upd;
            roll_best_next = roll_best_upd;
            learned_next   = 1'b1;
            if (!drop_hit) begin
              hold_next = '0;
            end else begin
              hold_next = hold_upd;
              if (hold_upd >= trhc_pkg::ms_to_us(regs.hold_time_ms) &&
                  roll_dev_mag > {2'b00, regs.roll_dead_band}) begin
                correction_next = correction_upd;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid   <= 1'b0;
      mode_reg       <= trhc_pkg::MODE_UNINIT;
      learned_flag   <= 1'b0;
      best_abs_pitch <= '0;
      roll_best      <= '0;
      learn_time_us  <= '0;
      hold_time_us   <= '0;
    end else begin
      if (advance) begin
        result.valid   <= 1'b1;
        mode_reg       <= mode_next;
        learned_flag   <= learned_next;
        best_abs_pitch <= best_next;
        roll_best      <= roll_best_next;
        learn_time_us  <= learn_next;
        hold_time_us   <= hold_next;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.correction <= correction_next;
      result.mode       <= mode_next;
    end
  end

endmodule

>>> src/tilt_reference_heading_corrector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt reference heading corrector
// Filters IMU pitch and roll, learns the best pitch and turns a held pitch
// drop with a roll deviation into a signed heading correction.
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle unless the result channel stalls; the
// pitch and roll filter update, with its single multiplier per axis, is
// the longest loop in the filter stage.
// Reset (rst, synchronous, active high) restores the register defaults,
// clears all learning state and empties the pipeline; no clearing pass.
// ----------------------------------------------------------------------------
module tilt_reference_heading_corrector (
  input  logic            clk,
  input  logic            rst,
  trhc_cfg_if.sink        cfg,
  trhc_sample_if.sink     sample,
  trhc_result_if.source   result
);

  // The datapath is a four-register pipeline: input register, filter
  // register, angle/decay register and result register. Each register
  // loads when it is empty or when the stage after it takes its transfer,
  // so a waiting result never blocks samples from filling the empty stages.
  //
  // State lives in two places. The filter stage keeps the enable flag, the
  // filter accumulators and the stable window counters; the mode stage keeps
  // the mode, the best pitch, the roll at that pitch and the learn and hold
  // timers. Both update only when a transfer passes through them, so each
  // sample sees exactly the state its predecessor left behind. An enable
  // change is detected in the filter stage and travels with the sample so
  // that the mode stage clears its own state at the same point in the
  // sample stream.
  //
  // The decay step floor(rate * interval / 1000000) is kept out of the
  // state loops: the product is formed in the filter stage and divided by a
  // reciprocal multiplication in the decay stage, ready for the mode stage.
  //
  // Registers must be written by the user only while the pipeline holds
  // no sample (the block does not enforce it), so every stage may read them directly.

  trhc_pkg::cfg_t   regs;

  logic             filt_valid;
  logic             filt_ready;
  trhc_pkg::filt_t  filt;

  logic             tilt_valid;
  logic             tilt_ready;
  trhc_pkg::tilt_t  tilt;

  trhc_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  trhc_filter_stage u_filter_stage (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample),
    .regs       (regs),
    .filt_valid (filt_valid),
    .filt       (filt),
    .filt_ready (filt_ready)
  );

  trhc_decay_stage u_decay_stage (
    .clk        (clk),
    .rst        (rst),
    .filt_valid (filt_valid),
    .filt       (filt),
    .filt_ready (filt_ready),
    .tilt_valid (tilt_valid),
    .tilt       (tilt),
    .tilt_ready (tilt_ready)
  );

  trhc_mode_stage u_mode_stage (
    .clk        (clk),
    .rst        (rst),
    .regs       (regs),
    .tilt_valid (tilt_valid),
    .tilt       (tilt),
    .tilt_ready (tilt_ready),
    .result     (result)
  );

endmodule

>>> src/trhc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt reference heading corrector checker
// Port-level assertions on the result channel and sample ready, bound to the top level.
// ----------------------------------------------------------------------------
module trhc_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [trhc_pkg::AngleW-1:0] correction,
  input logic [1:0]                         mode
);

  // The pipeline is empty and ready for a sample right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  // A stalled result keeps its value.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(correction) && $stable(mode))
    else $error("stalled result changed");

  // Only the tracking mode produces a correction.
  a_zero_outside_track: assert property (@(posedge clk) disable iff (rst)
    out_valid && (mode != trhc_pkg::MODE_TRACK) |-> correction == '0)
    else $error("correction outside tracking mode");

  // Any correction is at least the minimum effective output.
  a_min_output: assert property (@(posedge clk) disable iff (rst)
    out_valid && (correction != '0) |->
      (correction >= trhc_pkg::AngleW'(trhc_pkg::MinEffectiveOutput)) ||
      (correction <= -trhc_pkg::AngleW'(trhc_pkg::MinEffectiveOutput)))
    else $error("correction below minimum effective output");

endmodule

bind tilt_reference_heading_corrector trhc_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (sample.ready),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .correction (result.correction),
  .mode       (result.mode)
);

>>> tb/tilt_reference_heading_corrector_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt reference heading corrector testbench
// Drives IMU samples and register writes into the corrector. A behavioural
// model of the filters, the mode machine and the correction law predicts
// every result. Each transfer on the result channel is checked field by field
// against the oldest prediction. Idle and stall rates vary by phase, and one
// long receiver hold-off backs the pipeline up into the sample channel.
// ----------------------------------------------------------------------------
module tilt_reference_heading_corrector_test;

  // The watchdog gives up after this many cycles without any transfer.
  localparam int QuietLimit    = 3000;
  // Length of the long receiver hold-off, in cycles.
  localparam int HoldOffCycles = 300;
  // Cycles allowed after the last result for anything unexpected to appear.
  localparam int SettleCycles  = 8;

  typedef struct {
    logic signed [trhc_pkg::AngleW-1:0] correction;
    trhc_pkg::mode_t                    mode;
  } heading_result_t;

  logic clk = 1'b0;
  logic rst;

  trhc_cfg_if    cfg_ch ();
  trhc_sample_if smp ();
  trhc_result_if res ();

  tilt_reference_heading_corrector dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .sample (smp),
    .result (res)
  );

  always #5 clk = ~clk;

  // Samples waiting to be offered, and the results predicted for samples
  // that the block has already taken.
  trhc_pkg::sample_t queued_samples[$];
  heading_result_t   pending_corrections[$];
  trhc_pkg::sample_t on_offer;

  // Idle rates of the current phase, in percent.
  int send_idle_pct = 0;
  int stall_pct_now = 0;

  // Long hold-off requests from the stimulus, served by the result process.
  int holdoff_asked  = 0;
  int holdoff_served = 0;
  int holdoff_left   = 0;

  int mismatches   = 0;
  int quiet_cycles = 0;

  // --------------------------------------------------------------------------
  // Behavioural model of the corrector: register copies and learning state.
  // --------------------------------------------------------------------------
  trhc_pkg::cfg_t             model_cfg;
  bit                         en_state;
  bit                         seeded;
  bit                         learned;
  trhc_pkg::mode_t            mode_now;
  int                         pitch_acc;     // filtered pitch, angle units scaled by 2^16
  int                         roll_acc;      // filtered roll, same scaling
  int unsigned                best_pitch;    // best absolute pitch seen while learning or tracking
  int                         roll_ref;      // filtered roll at the best pitch
  logic [trhc_pkg::TimeW-1:0] stable_us;
  logic [trhc_pkg::TimeW-1:0] learn_us;
  logic [trhc_pkg::TimeW-1:0] hold_us;
  int                         stable_count;  // saturates at two

  function automatic logic [trhc_pkg::TimeW-1:0] time_add(
      input logic [trhc_pkg::TimeW-1:0] acc,
      input logic [trhc_pkg::IntervalW-1:0] dt);
    logic [trhc_pkg::TimeW:0] total;
    total = acc + dt;
    return total[trhc_pkg::TimeW] ? {trhc_pkg::TimeW{1'b1}} : total[trhc_pkg::TimeW-1:0];
  endfunction

  function automatic logic [trhc_pkg::TimeW-1:0] ms_in_us(input logic [trhc_pkg::MsW-1:0] ms);
    return 32'(ms) * 32'd1000;
  endfunction

  // Round half up from the scaled accumulator back to angle units.
  function automatic int angle_deg(input int acc);
    return int'((longint'(acc) + 64'sd32768) >>> 16);
  endfunction

  // One step of the first-order low-pass filter. A gain above one is held
  // at one, and the arithmetic shift floors the scaled step.
  function automatic int filter_step(input int acc, input int angle,
                                     input logic [trhc_pkg::GainW-1:0] gain);
    longint g;
    longint diff;
    g    = (gain > trhc_pkg::GainOne) ? 64'sd65536 : longint'(gain);
    diff = longint'(angle) * 65536 - longint'(acc);
    return int'(longint'(acc) + ((g * diff) >>> 16));
  endfunction

  function automatic bit window_open();
    return stable_count >= 2 && stable_us >= ms_in_us(model_cfg.warmup_time_ms);
  endfunction

  function automatic void clear_learning();
    seeded       = 1'b0;
    learned      = 1'b0;
    mode_now     = trhc_pkg::MODE_UNINIT;
    pitch_acc    = 0;
    roll_acc     = 0;
    best_pitch   = 0;
    roll_ref     = 0;
    stable_us    = '0;
    stable_count = 0;
    learn_us     = '0;
    hold_us      = '0;
  endfunction

  // Decay the best pitch by the elapsed time, then take the current pitch as
  // the new best if it beats the old one by more than the improvement margin.
  function automatic void refresh_best(input logic [trhc_pkg::IntervalW-1:0] dt);
    int          p;
    int unsigned pa;
    logic [63:0] drain;
    p  = angle_deg(pitch_acc);
    pa = (p < 0) ? -p : p;
    if (learned && model_cfg.best_decay_rate != 0 && dt != 0) begin
      drain      = (64'(model_cfg.best_decay_rate) * 64'(dt)) / 64'd1000000;
      best_pitch = (drain >= 64'(best_pitch)) ? 0 : best_pitch - drain[31:0];
    end
    if (!learned || pa > best_pitch + trhc_pkg::LearnImproveEps) begin
      best_pitch = pa;
      roll_ref   = angle_deg(roll_acc);
      learned    = 1'b1;
    end
  endfunction

  // Correction law in the tracking mode.
  function automatic int track_drop(input logic [trhc_pkg::IntervalW-1:0] dt);
    int p;
    int pa;
    int drop;
    int rd;
    int rda;
    int mag;
    p    = angle_deg(pitch_acc);
    pa   = (p < 0) ? -p : p;
    drop = int'(best_pitch) - pa;
    if (drop <= int'(model_cfg.drop_threshold)) begin
      hold_us = '0;
      return 0;
    end
    hold_us = time_add(hold_us, dt);
    if (hold_us < ms_in_us(model_cfg.hold_time_ms))
      return 0;
    rd  = angle_deg(roll_acc) - roll_ref;
    rda = (rd < 0) ? -rd : rd;
    if (rda <= int'(model_cfg.roll_dead_band))
      return 0;
    mag = (drop > int'(model_cfg.output_limit)) ? int'(model_cfg.output_limit) : drop;
    if (mag > 0 && mag < trhc_pkg::MinEffectiveOutput)
      mag = trhc_pkg::MinEffectiveOutput;
    return (rd > 0) ? mag : -mag;
  endfunction

  // Advance the model by one sample and return the result it must give.
  function automatic heading_result_t predict_correction(input trhc_pkg::sample_t s);
    heading_result_t r;
    int              corr;
    corr = 0;
    if (s.enable != en_state) begin
      en_state = s.enable;
      clear_learning();
    end
    if (en_state) begin
      if (!seeded) begin
        pitch_acc = int'(s.pitch_angle) * 65536;
        roll_acc  = int'(s.roll_angle) * 65536;
        seeded    = 1'b1;
      end else begin
        pitch_acc = filter_step(pitch_acc, int'(s.pitch_angle), model_cfg.pitch_filter_gain);
        roll_acc  = filter_step(roll_acc, int'(s.roll_angle), model_cfg.roll_filter_gain);
      end
      stable_us = time_add(stable_us, s.interval_us);
      if (stable_count < 2)
        stable_count++;
      case (mode_now)
        trhc_pkg::MODE_UNINIT: begin
          if (window_open()) begin
            mode_now = trhc_pkg::MODE_LEARN;
            learn_us = '0;
          end
        end
        trhc_pkg::MODE_LEARN: begin
          if (window_open()) begin
            refresh_best(s.interval_us);
            learn_us = time_add(learn_us, s.interval_us);
            if (learned && learn_us >= ms_in_us(model_cfg.warmup_time_ms)) begin
              mode_now = trhc_pkg::MODE_TRACK;
              hold_us  = '0;
            end
          end
        end
        default: begin
          if (!window_open()) begin
            hold_us = '0;
          end else begin
            refresh_best(s.interval_us);
            corr = track_drop(s.interval_us);
          end
        end
      endcase
    end
    r.correction = trhc_pkg::AngleW'(corr);
    r.mode       = mode_now;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Sample driver. A sample is predicted at the edge of its transfer; the next
  // one is offered at once unless the sender idles this cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_samples
    trhc_pkg::sample_t nxt;
    if (rst) begin
      smp.valid <= 1'b0;
    end else begin
      if (smp.valid && smp.ready)
        pending_corrections.push_back(predict_correction(on_offer));
      if (!smp.valid || smp.ready) begin
        if (queued_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = queued_samples.pop_front();
          on_offer = nxt;
          smp.valid       <= 1'b1;
          smp.pitch_angle <= nxt.pitch_angle;
          smp.roll_angle  <= nxt.roll_angle;
          smp.interval_us <= nxt.interval_us;
          smp.enable      <= nxt.enable;
        end else begin
          smp.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor. Each transfer is compared with the oldest prediction. The
  // ready line follows the stall rate, except during a long hold-off, whose
  // length this process counts itself.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    heading_result_t want;
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (pending_corrections.size() == 0) begin
          $display("%0t: result with nothing expected: correction %0d, mode %0d",
                   $time, res.correction, res.mode);
          mismatches++;
        end else begin
          want = pending_corrections.pop_front();
          if (res.correction !== want.correction) begin
            $display("%0t: correction expected %0d, actual %0d",
                     $time, want.correction, res.correction);
            mismatches++;
          end
          if (res.mode !== want.mode) begin
            $display("%0t: mode expected %0d, actual %0d", $time, want.mode, res.mode);
            mismatches++;
          end
        end
      end
      if (holdoff_left != 0) begin
        holdoff_left--;
      end else if (holdoff_served != holdoff_asked) begin
        holdoff_left = HoldOffCycles;
        holdoff_served++;
      end
      res.ready <= (holdoff_left == 0) && ($urandom_range(99) >= stall_pct_now);
    end
  end

  // Watchdog: a run that stops moving is a failure.
  always @(posedge clk) begin
    if (rst || (smp.valid && smp.ready) || (res.valid && res.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("tilt_reference_heading_corrector_test: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  function automatic trhc_pkg::cfg_t settings(input int warmup, hold, p_gain, r_gain,
                                              decay, drop, band, limit);
    trhc_pkg::cfg_t c;
    c.warmup_time_ms    = trhc_pkg::MsW'(warmup);
    c.hold_time_ms      = trhc_pkg::MsW'(hold);
    c.pitch_filter_gain = trhc_pkg::GainW'(p_gain);
    c.roll_filter_gain  = trhc_pkg::GainW'(r_gain);
    c.best_decay_rate   = trhc_pkg::MsW'(decay);
    c.drop_threshold    = trhc_pkg::LimW'(drop);
    c.roll_dead_band    = trhc_pkg::LimW'(band);
    c.output_limit      = trhc_pkg::LimW'(limit);
    return c;
  endfunction

  task automatic queue_sample(input int pitch, input int roll, input int interval,
                              input bit en);
    trhc_pkg::sample_t s;
    s.pitch_angle = trhc_pkg::AngleW'(pitch);
    s.roll_angle  = trhc_pkg::AngleW'(roll);
    s.interval_us = trhc_pkg::IntervalW'(interval);
    s.enable      = en;
    queued_samples.push_back(s);
  endtask

  // Wait, sampling on the falling edge, until no sample is queued or on offer
  // and every predicted result has arrived.
  task automatic await_idle();
    do @(negedge clk);
    while (queued_samples.size() != 0 || smp.valid || pending_corrections.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Called just after a rising edge; the model takes each value as its
  // transfer completes. Valid is held high across back-to-back writes.
  task automatic write_reg(input trhc_pkg::cfg_idx_t idx,
                           input logic [trhc_pkg::CfgDataW-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk);
    while (!cfg_ch.ready);
    case (idx)
      trhc_pkg::REG_WARMUP_TIME:
        model_cfg.warmup_time_ms    = value[trhc_pkg::MsW-1:0];
      trhc_pkg::REG_HOLD_TIME:
        model_cfg.hold_time_ms      = value[trhc_pkg::MsW-1:0];
      trhc_pkg::REG_PITCH_GAIN:
        model_cfg.pitch_filter_gain = value[trhc_pkg::GainW-1:0];
      trhc_pkg::REG_ROLL_GAIN:
        model_cfg.roll_filter_gain  = value[trhc_pkg::GainW-1:0];
      trhc_pkg::REG_DECAY_RATE:
        model_cfg.best_decay_rate   = value[trhc_pkg::MsW-1:0];
      trhc_pkg::REG_DROP_THRESHOLD:
        model_cfg.drop_threshold    = value[trhc_pkg::LimW-1:0];
      trhc_pkg::REG_DEAD_BAND:
        model_cfg.roll_dead_band    = value[trhc_pkg::LimW-1:0];
      trhc_pkg::REG_OUTPUT_LIMIT:
        model_cfg.output_limit      = value[trhc_pkg::LimW-1:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input trhc_pkg::cfg_t c);
    @(posedge clk);
    write_reg(trhc_pkg::REG_WARMUP_TIME,    trhc_pkg::CfgDataW'(c.warmup_time_ms));
    write_reg(trhc_pkg::REG_HOLD_TIME,      trhc_pkg::CfgDataW'(c.hold_time_ms));
    write_reg(trhc_pkg::REG_PITCH_GAIN,     trhc_pkg::CfgDataW'(c.pitch_filter_gain));
    write_reg(trhc_pkg::REG_ROLL_GAIN,      trhc_pkg::CfgDataW'(c.roll_filter_gain));
    write_reg(trhc_pkg::REG_DECAY_RATE,     trhc_pkg::CfgDataW'(c.best_decay_rate));
    write_reg(trhc_pkg::REG_DROP_THRESHOLD, trhc_pkg::CfgDataW'(c.drop_threshold));
    write_reg(trhc_pkg::REG_DEAD_BAND,      trhc_pkg::CfgDataW'(c.roll_dead_band));
    write_reg(trhc_pkg::REG_OUTPUT_LIMIT,   trhc_pkg::CfgDataW'(c.output_limit));
    cfg_ch.valid <= 1'b0;
  endtask

  // Random traffic. Most of it is tilt episodes: the pitch climbs to a peak,
  // so that there is something to learn, and then falls back while the roll
  // moves off its old value, which is what makes the block correct. About
  // one episode in three carries on without a clearing sample, so state
  // builds up across episodes. The rest is raw noise over every bit of every
  // field. Only enabled samples count towards the goal.
  task automatic queue_traffic(input int active_goal, input int lo, input int hi);
    logic [63:0]       raw;
    trhc_pkg::sample_t s;
    int                active;
    int                len;
    int                peak_at;
    int                peak;
    int                sgn;
    int                roll0;
    int                roll_step;
    int                drop_pct;
    int                k;
    int                p;
    active = 0;
    while (active < active_goal) begin
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(1, 4)) begin
          raw = {$urandom, $urandom};
          s   = raw[$bits(trhc_pkg::sample_t)-1:0];
          queued_samples.push_back(s);
          if (s.enable)
            active++;
        end
      end else begin
        len       = $urandom_range(15, 60);
        peak_at   = $urandom_range(3, len / 2);
        peak      = $urandom_range(200, 20000);
        sgn       = $urandom_range(1) ? 1 : -1;
        roll0     = int'($urandom_range(20000)) - 10000;
        roll_step = int'($urandom_range(6000)) - 3000;
        drop_pct  = $urandom_range(30, 100);
        if ($urandom_range(99) < 65)
          queue_sample(int'($urandom_range(65535)), int'($urandom_range(65535)),
                       int'($urandom_range(1048575)), 1'b0);
        for (k = 0; k < len; k++) begin
          if (k <= peak_at)
            p = peak * k / peak_at;
          else
            p = peak - peak * (k - peak_at) * drop_pct / (100 * (len - peak_at));
          queue_sample(sgn * p + int'($urandom_range(40)) - 20,
                       roll0 + ((k > peak_at) ? roll_step : 0) + int'($urandom_range(40)) - 20,
                       ($urandom_range(19) == 0) ? 0 : int'($urandom_range(hi, lo)),
                       1'b1);
          active++;
        end
      end
    end
  endtask

  task automatic run_phase(input trhc_pkg::cfg_t c, input int send_pct, input int stall_pct,
                           input int lo, input int hi, input int goal);
    await_idle();
    send_idle_pct = send_pct;
    stall_pct_now = stall_pct;
    load_settings(c);
    queue_traffic(goal, lo, hi);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    rst              = 1'b1;
    smp.valid        = 1'b0;
    smp.pitch_angle  = '0;
    smp.roll_angle   = '0;
    smp.interval_us  = '0;
    smp.enable       = 1'b0;
    res.ready        = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = trhc_pkg::REG_WARMUP_TIME;
    cfg_ch.data      = '0;
    model_cfg        = settings(500, 200, 16384, 16384, 0, 128, 64, 1280);
    en_state         = 1'b0;
    clear_learning();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Short windows and instant filters make each sample's
    // effect easy to follow; the roll gain sits above one and must act as one.
    await_idle();
    load_settings(settings(10, 5, 65536, 'h18000, 0, 10, 20, 1000));
    queue_sample(32767, -32768, 1048575, 1'b0);  // disabled: nothing moves
    queue_sample(-32768, 32767, 0, 1'b1);        // enable change, seeding, no time
    queue_sample(1000, 0, 20000, 1'b1);          // window full, learning starts
    queue_sample(1000, 0, 20000, 1'b1);          // best learned, tracking starts
    queue_sample(970, 100, 20000, 1'b1);         // small drop raised to the minimum
    queue_sample(0, -500, 20000, 1'b1);          // drop equal to the limit
    queue_sample(-5000, -500, 20000, 1'b1);      // new best while tracking
    queue_sample(-100, -510, 0, 1'b1);           // drop, but no hold time counted
    queue_sample(-100, -510, 20000, 1'b1);       // held, roll inside the dead band
    queue_sample(-100, 3000, 20000, 1'b1);       // held, roll outside: correction
    queue_sample(0, 0, 20000, 1'b0);             // enable change clears everything
    queue_sample(0, 0, 20000, 1'b0);             // stays disabled
    queue_sample(32767, -32768, 1048575, 1'b1);
    queue_sample(-32768, 32767, 1048575, 1'b1);
    queue_sample(-32768, 32767, 1048575, 1'b1);
    queue_sample(32767, -32768, 1048575, 1'b1);  // drop of one, below threshold
    queue_sample(0, -32768, 1048575, 1'b1);      // widest drop and roll swing
    queue_sample(0, 0, 0, 1'b0);

    // Random phases, each with its own settings and its own idling mix.
    run_phase(settings(100, 40, 16384, 16384, 0, 128, 64, 1280), 0, 0, 2000, 20000, 170);
    // The sender keeps offering while the receiver holds off, so the block
    // fills up and has to stall its input.
    holdoff_asked <= holdoff_asked + 1;
    // A longer run at the largest interval, with the pitch held well below
    // its early peak, keeps the hold timer counting across many samples.
    queue_sample(0, 0, 0, 1'b0);
    queue_sample($urandom_range(1) ? 18000 : -18000, 0, 1048575, 1'b1);
    repeat (200)
      queue_sample(int'($urandom_range(200)) - 100, int'($urandom_range(8000)) - 4000,
                   1048575, 1'b1);

    run_phase(settings(0, 0, 65536, 'h1FFFF, 65535, 0, 0, 23040), 45, 0, 0, 20000, 170);
    run_phase(settings(65535, 65535, 0, 0, 1, 23040, 23040, 0), 0, 45, 500000, 1048575, 170);
    run_phase(settings(50, 20, 30000, 50000, 2000, 300, 100, 700), 25, 25, 2000, 10000, 170);
    run_phase(settings(500, 200, 16384, 16384, 0, 128, 64, 1280), 0, 0, 10000, 60000, 170);

    // Drain, then leave room for any stray result to show up.
    await_idle();
    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("tilt_reference_heading_corrector_test: done, clean");
    end else begin
      $display("tilt_reference_heading_corrector_test: done, errors");
    end
    $finish;
  end

endmodule
